/* hdl/kgp_pkg.sv */
// Shared constants, types and register codes for the kinship genotype probability block.
package kgp_pkg;

    localparam int ALLELE_COUNT_DEF = 64;

    localparam int AL_W       = 6;
    localparam int GENO_W     = 12;
    localparam int FREQ_W     = 16;
    localparam int CNT_W      = 10;
    localparam int THETA_W    = 16;
    localparam int KAPPA_W    = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int PROB_W     = 32;

    // four allele probability lanes, one divider lane each
    localparam int LANES   = 4;
    localparam int LN_PA   = 0;   // f1, c1,   n
    localparam int LN_HOM2 = 1;   // f1, c1+1, n+1
    localparam int LN_HET2 = 2;   // f2, c2,   n+1
    localparam int LN_PB   = 3;   // f2, c2,   n

    localparam int QW    = PROB_W;  // quotient bits, one per divider stage
    localparam int NUM_W = 44;
    localparam int DEN_W = 27;
    localparam int DVD_W = 58;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THETA       = 3'd0,
        CFG_TYPED_TOTAL = 3'd1,
        CFG_KAPPA_ZERO  = 3'd2,
        CFG_KAPPA_ONE   = 3'd3,
        CFG_KAPPA_TWO   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic rel;
        logic same;
        logic uhom;
        logic a_sh;
        logic b_sh;
        logic rhom;
    } t_ctl;

    typedef struct packed {
        logic [DVD_W-1:0] dvd;
        logic [DEN_W-1:0] den;
    } t_div_in;

endpackage

/* hdl/kgp_prep.sv */
// Front end: genotype flags and the dividends and divisors of the four allele probabilities.
module kgp_prep #(
    parameter int ALLELE_COUNT = kgp_pkg::ALLELE_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [kgp_pkg::GENO_W-1:0]      i_unknown_geno,
    input  logic [kgp_pkg::GENO_W-1:0]      i_related_geno,
    input  logic                            i_related_present,
    input  logic [kgp_pkg::AL_W-1:0]        i_unk_allele_first,
    input  logic [kgp_pkg::AL_W-1:0]        i_unk_allele_second,
    input  logic [kgp_pkg::AL_W-1:0]        i_rel_allele_first,
    input  logic [kgp_pkg::AL_W-1:0]        i_rel_allele_second,
    input  logic [kgp_pkg::FREQ_W-1:0]      i_freq_first,
    input  logic [kgp_pkg::FREQ_W-1:0]      i_freq_second,
    input  logic [kgp_pkg::CNT_W-1:0]       i_count_first,
    input  logic [kgp_pkg::CNT_W-1:0]       i_count_second,
    input  logic [kgp_pkg::THETA_W-1:0]     i_theta,
    input  logic [kgp_pkg::CNT_W-1:0]       i_typed_total,
    output logic                            o_valid,
    output kgp_pkg::t_div_in [kgp_pkg::LANES-1:0] o_div,
    output kgp_pkg::t_ctl                   o_ctl
);
    import kgp_pkg::*;

    localparam int C_W  = CNT_W + 1;
    localparam int CT_W = C_W + THETA_W;
    localparam int FT_W = THETA_W + 1 + FREQ_W;

    // allele index reduction table, constant
    logic [AL_W-1:0] w_id_tab [2**AL_W];
    for (genvar i = 0; i < 2**AL_W; i++) begin : g_tab
        assign w_id_tab[i] = AL_W'(i % ALLELE_COUNT);
    end

    logic [AL_W-1:0] w_ua, w_ub, w_ra, w_rb;
    t_ctl            n_ctl;
    logic [C_W-1:0]    w_c [LANES];
    logic [FREQ_W-1:0] w_f [LANES];
    logic [C_W-1:0]    w_n1;

    assign w_ua = w_id_tab[i_unk_allele_first];
    assign w_ub = w_id_tab[i_unk_allele_second];
    assign w_ra = w_id_tab[i_rel_allele_first];
    assign w_rb = w_id_tab[i_rel_allele_second];

    always_comb begin
        n_ctl.rel  = i_related_present;
        n_ctl.same = (i_unknown_geno == i_related_geno);
        n_ctl.uhom = (w_ua == w_ub);
        n_ctl.a_sh = (w_ua == w_ra) || (w_ua == w_rb);
        n_ctl.b_sh = (w_ub == w_ra) || (w_ub == w_rb);
        n_ctl.rhom = (w_ra == w_rb);
    end

    assign w_c[LN_PA]   = {1'b0, i_count_first};
    assign w_c[LN_HOM2] = {1'b0, i_count_first} + C_W'(1);
    assign w_c[LN_HET2] = {1'b0, i_count_second};
    assign w_c[LN_PB]   = {1'b0, i_count_second};
    assign w_f[LN_PA]   = i_freq_first;
    assign w_f[LN_HOM2] = i_freq_first;
    assign w_f[LN_HET2] = i_freq_second;
    assign w_f[LN_PB]   = i_freq_second;
    assign w_n1         = {1'b0, i_typed_total} + C_W'(1);

    // stage 1: products
    logic [CT_W-1:0] r1_ct  [LANES];
    logic [FT_W-1:0] r1_ft  [LANES];
    logic [CT_W-1:0] r1_nth [2];
    t_ctl            r1_ctl;
    // stage 2: numerator and divisor
    logic [NUM_W-1:0] r2_num [LANES];
    logic [DEN_W-1:0] r2_den [LANES];
    t_ctl             r2_ctl;
    // stage 3: rounded dividend
    logic [DVD_W-1:0] r3_dvd [LANES];
    logic [DEN_W-1:0] r3_den [LANES];
    t_ctl             r3_ctl;
    logic [2:0]       r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < LANES; l++) begin
                r1_ct[l] <= CT_W'(w_c[l]) * CT_W'(i_theta);
                r1_ft[l] <= FT_W'(17'd65536 - {1'b0, i_theta}) * FT_W'(w_f[l]);
            end
            r1_nth[0] <= CT_W'(i_typed_total) * CT_W'(i_theta);
            r1_nth[1] <= CT_W'(w_n1) * CT_W'(i_theta);
            r1_ctl    <= n_ctl;

            for (int l = 0; l < LANES; l++) begin
                r2_num[l] <= (NUM_W'(r1_ct[l]) << 16) + NUM_W'(r1_ft[l]);
                if (l == LN_HOM2 || l == LN_HET2) begin
                    r2_den[l] <= DEN_W'(65536) + DEN_W'(r1_nth[1]) - DEN_W'(i_theta);
                end else begin
                    r2_den[l] <= DEN_W'(65536) + DEN_W'(r1_nth[0]) - DEN_W'(i_theta);
                end
            end
            r2_ctl <= r1_ctl;

            for (int l = 0; l < LANES; l++) begin
                r3_dvd[l] <= (DVD_W'(r2_num[l]) << 14) + DVD_W'(r2_den[l] >> 1);
                r3_den[l] <= r2_den[l];
            end
            r3_ctl <= r2_ctl;
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_div[l].dvd = r3_dvd[l];
            o_div[l].den = r3_den[l];
        end
    end
    assign o_ctl   = r3_ctl;
    assign o_valid = r_vld[2];

endmodule

/* hdl/kgp_div.sv */
// Pipelined restoring divider, four lanes, one quotient bit per stage, saturating.
module kgp_div (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  kgp_pkg::t_div_in [kgp_pkg::LANES-1:0]  i_div,
    input  kgp_pkg::t_ctl                          i_ctl,
    output logic                                   o_valid,
    output logic [kgp_pkg::LANES-1:0][kgp_pkg::QW-1:0] o_quot,
    output kgp_pkg::t_ctl                          o_ctl
);
    import kgp_pkg::*;

    logic [DVD_W-1:0] r_rem [QW][LANES];
    logic [DEN_W-1:0] r_den [QW][LANES];
    logic [QW-1:0]    r_q   [QW][LANES];
    logic             r_ovf [QW][LANES];
    t_ctl             r_ctl [QW];
    logic [QW-1:0]    r_vld;

    logic [DVD_W-1:0] w_rem [QW][LANES];
    logic [DEN_W-1:0] w_den [QW][LANES];
    logic [QW-1:0]    w_q   [QW][LANES];
    logic             w_ovf [QW][LANES];
    t_ctl             w_ctl [QW];

    logic [DVD_W-1:0] n_rem [QW][LANES];
    logic [QW-1:0]    n_q   [QW][LANES];
    logic [DVD_W:0]   w_sub;

    for (genvar s = 0; s < QW; s++) begin : g_in
        if (s == 0) begin : g_first
            for (genvar l = 0; l < LANES; l++) begin : g_ln
                assign w_rem[s][l] = i_div[l].dvd;
                assign w_den[s][l] = i_div[l].den;
                assign w_q[s][l]   = '0;
                // quotient would not fit: saturate
                assign w_ovf[s][l] = {1'b0, i_div[l].dvd} >= ((DVD_W+1)'(i_div[l].den) << QW);
            end
            assign w_ctl[s] = i_ctl;
        end else begin : g_next
            for (genvar l = 0; l < LANES; l++) begin : g_ln
                assign w_rem[s][l] = r_rem[s-1][l];
                assign w_den[s][l] = r_den[s-1][l];
                assign w_q[s][l]   = r_q[s-1][l];
                assign w_ovf[s][l] = r_ovf[s-1][l];
            end
            assign w_ctl[s] = r_ctl[s-1];
        end
    end

    always_comb begin
        w_sub = '0;
        for (int s = 0; s < QW; s++) begin
            for (int l = 0; l < LANES; l++) begin
                w_sub = {1'b0, w_rem[s][l]} - ((DVD_W+1)'(w_den[s][l]) << (QW - 1 - s));
                n_q[s][l] = w_q[s][l];
                n_q[s][l][QW-1-s] = !w_sub[DVD_W];
                n_rem[s][l] = w_sub[DVD_W] ? w_rem[s][l] : w_sub[DVD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < QW; s++) begin
                for (int l = 0; l < LANES; l++) begin
                    r_rem[s][l] <= n_rem[s][l];
                    r_den[s][l] <= w_den[s][l];
                    r_q[s][l]   <= n_q[s][l];
                    r_ovf[s][l] <= w_ovf[s][l];
                end
                r_ctl[s] <= w_ctl[s];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quot[l] = r_ovf[QW-1][l] ? '1 : r_q[QW-1][l];
        end
    end
    assign o_ctl   = r_ctl[QW-1];
    assign o_valid = r_vld[QW-1];

endmodule

/* hdl/kgp_comb.sv */
// Back end: match probability product, kappa scaling and terms, saturation.
module kgp_comb (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_en,
    input  logic                                       i_valid,
    input  logic [kgp_pkg::LANES-1:0][kgp_pkg::QW-1:0] i_quot,
    input  kgp_pkg::t_ctl                              i_ctl,
    input  logic [kgp_pkg::KAPPA_W-1:0]                i_kappa_zero,
    input  logic [kgp_pkg::KAPPA_W-1:0]                i_kappa_one,
    input  logic [kgp_pkg::KAPPA_W-1:0]                i_kappa_two,
    output logic                                       o_valid,
    output logic [kgp_pkg::PROB_W-1:0]                 o_probability
);
    import kgp_pkg::*;

    localparam int PR_W   = 2 * QW;
    localparam int T_W    = QW + 1;
    localparam int TK_W   = T_W + KAPPA_W;
    localparam int G0_W   = 36;
    localparam int TERM_W = 35;
    localparam int GK_W   = G0_W + KAPPA_W;
    localparam int SUM_W  = 40;

    logic [QW-1:0]  w_pa, w_pb, w_sel;
    logic [T_W-1:0] n1_t;
    logic           n1_sh16;

    assign w_pa  = i_quot[LN_PA];
    assign w_pb  = i_quot[LN_PB];
    assign w_sel = i_ctl.uhom ? i_quot[LN_HOM2] : i_quot[LN_HET2];

    // kappa one operand and its halving
    always_comb begin
        n1_t    = '0;
        n1_sh16 = 1'b0;
        if (i_ctl.rel) begin
            if (i_ctl.same) begin
                if (i_ctl.uhom) begin
                    n1_t    = {1'b0, w_pa};
                    n1_sh16 = 1'b1;
                end else begin
                    n1_t = {1'b0, w_pa} + {1'b0, w_pb};
                end
            end else if (i_ctl.a_sh || i_ctl.b_sh) begin
                if (i_ctl.uhom) begin
                    n1_t = {1'b0, w_pa};
                end else begin
                    n1_t    = i_ctl.a_sh ? {1'b0, w_pb} : {1'b0, w_pa};
                    n1_sh16 = i_ctl.rhom;
                end
            end
        end
    end

    logic [PR_W-1:0]   r1_prod;
    logic [TK_W-1:0]   r1_tk;
    logic              r1_sh16;
    t_ctl              r1_ctl;
    logic [G0_W-1:0]   r2_g0;
    logic [TERM_W-1:0] r2_term;
    t_ctl              r2_ctl;
    logic [GK_W-1:0]   r3_gk;
    logic [G0_W-1:0]   r3_g0;
    logic [TERM_W-1:0] r3_term;
    t_ctl              r3_ctl;
    logic [PROB_W-1:0] r4_prob;
    logic [3:0]        r_vld;

    logic [PR_W-1:0]   w_g0r;
    logic [TK_W-1:0]   w_term;
    logic [GK_W-1:0]   w_gkr;
    logic [SUM_W-1:0]  w_sum;

    assign w_g0r  = ((r1_prod >> 29) + PR_W'(1)) >> 1;
    assign w_term = r1_sh16 ? (((r1_tk >> 15) + TK_W'(1)) >> 1)
                            : (((r1_tk >> 16) + TK_W'(1)) >> 1);
    assign w_gkr  = ((r3_gk >> 15) + GK_W'(1)) >> 1;

    always_comb begin
        if (r3_ctl.rel) begin
            w_sum = SUM_W'(w_gkr) + SUM_W'(r3_term);
            if (r3_ctl.same) begin
                w_sum = w_sum + (SUM_W'(i_kappa_two) << 14);
            end
        end else begin
            w_sum = SUM_W'(r3_g0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod <= PR_W'(w_pa) * PR_W'(w_sel);
            r1_tk   <= TK_W'(n1_t) * TK_W'(i_kappa_one);
            r1_sh16 <= n1_sh16;
            r1_ctl  <= i_ctl;

            r2_g0   <= r1_ctl.uhom ? G0_W'(w_g0r) : (G0_W'(w_g0r) << 1);
            r2_term <= TERM_W'(w_term);
            r2_ctl  <= r1_ctl;

            r3_gk   <= GK_W'(r2_g0) * GK_W'(i_kappa_zero);
            r3_g0   <= r2_g0;
            r3_term <= r2_term;
            r3_ctl  <= r2_ctl;

            r4_prob <= (w_sum[SUM_W-1:PROB_W] != '0) ? '1 : w_sum[PROB_W-1:0];
        end
    end

    assign o_valid       = r_vld[3];
    assign o_probability = r4_prob;

endmodule

/* hdl/kinship_genotype_probability.sv */
// Top level of the kinship-aware genotype probability block.
// Takes one transaction per clock while the output is not stalled and returns one
// probability per transaction, in order (3 front-end, 32 divider, 4 back-end stages).
// The rate is set by full staging: the four theta-corrected allele probabilities run
// side by side through a 32-stage restoring divider, one quotient bit per stage. A
// stall on the output freezes the whole pipeline, bubbles included; o_stall follows it.
// Registers are written through the plain write port and must only change while no
// transaction is in flight. Allele indices are reduced modulo ALLELE_COUNT before compare.
module kinship_genotype_probability #(
    parameter int ALLELE_COUNT = kgp_pkg::ALLELE_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [kgp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [kgp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [kgp_pkg::GENO_W-1:0]       i_unknown_geno,
    input  logic [kgp_pkg::GENO_W-1:0]       i_related_geno,
    input  logic                             i_related_present,
    input  logic [kgp_pkg::AL_W-1:0]         i_unk_allele_first,
    input  logic [kgp_pkg::AL_W-1:0]         i_unk_allele_second,
    input  logic [kgp_pkg::AL_W-1:0]         i_rel_allele_first,
    input  logic [kgp_pkg::AL_W-1:0]         i_rel_allele_second,
    input  logic [kgp_pkg::FREQ_W-1:0]       i_freq_first,
    input  logic [kgp_pkg::FREQ_W-1:0]       i_freq_second,
    input  logic [kgp_pkg::CNT_W-1:0]        i_count_first,
    input  logic [kgp_pkg::CNT_W-1:0]        i_count_second,
    // output channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [kgp_pkg::PROB_W-1:0]       o_probability
);
    import kgp_pkg::*;

    logic [THETA_W-1:0] r_theta;
    logic [CNT_W-1:0]   r_typed_total;
    logic [KAPPA_W-1:0] r_kappa_zero;
    logic [KAPPA_W-1:0] r_kappa_one;
    logic [KAPPA_W-1:0] r_kappa_two;

    // register file; unknown indices are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_theta       <= '0;
            r_typed_total <= '0;
            r_kappa_zero  <= KAPPA_W'(65536);
            r_kappa_one   <= '0;
            r_kappa_two   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THETA:       r_theta       <= i_cfg_data[THETA_W-1:0];
                CFG_TYPED_TOTAL: r_typed_total <= i_cfg_data[CNT_W-1:0];
                CFG_KAPPA_ZERO:  r_kappa_zero  <= i_cfg_data[KAPPA_W-1:0];
                CFG_KAPPA_ONE:   r_kappa_one   <= i_cfg_data[KAPPA_W-1:0];
                CFG_KAPPA_TWO:   r_kappa_two   <= i_cfg_data[KAPPA_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advances unless a finished result is held back
    logic w_en;
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    logic                     w_prep_vld;
    t_div_in [LANES-1:0]      w_div;
    t_ctl                     w_prep_ctl;
    logic                     w_div_vld;
    logic [LANES-1:0][QW-1:0] w_quot;
    t_ctl                     w_div_ctl;

    kgp_prep #(
        .ALLELE_COUNT (ALLELE_COUNT)
    ) u_prep (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_en                (w_en),
        .i_valid             (i_valid),
        .i_unknown_geno      (i_unknown_geno),
        .i_related_geno      (i_related_geno),
        .i_related_present   (i_related_present),
        .i_unk_allele_first  (i_unk_allele_first),
        .i_unk_allele_second (i_unk_allele_second),
        .i_rel_allele_first  (i_rel_allele_first),
        .i_rel_allele_second (i_rel_allele_second),
        .i_freq_first        (i_freq_first),
        .i_freq_second       (i_freq_second),
        .i_count_first       (i_count_first),
        .i_count_second      (i_count_second),
        .i_theta             (r_theta),
        .i_typed_total       (r_typed_total),
        .o_valid             (w_prep_vld),
        .o_div               (w_div),
        .o_ctl               (w_prep_ctl)
    );

    kgp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_prep_vld),
        .i_div   (w_div),
        .i_ctl   (w_prep_ctl),
        .o_valid (w_div_vld),
        .o_quot  (w_quot),
        .o_ctl   (w_div_ctl)
    );

    kgp_comb u_comb (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (w_div_vld),
        .i_quot        (w_quot),
        .i_ctl         (w_div_ctl),
        .i_kappa_zero  (r_kappa_zero),
        .i_kappa_one   (r_kappa_one),
        .i_kappa_two   (r_kappa_two),
        .o_valid       (o_valid),
        .o_probability (o_probability)
    );

endmodule

/* tb/tb_kinship_genotype_probability.sv */
// Self-checking testbench for the kinship genotype probability block.
module tb_kinship_genotype_probability;
    import kgp_pkg::*;

    localparam int LATENCY   = 39;
    localparam int MAX_CYC   = 400000;
    localparam int N_RANDOM  = 1300;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [GENO_W-1:0]     i_unknown_geno = '0;
    logic [GENO_W-1:0]     i_related_geno = '0;
    logic                  i_related_present = 1'b0;
    logic [AL_W-1:0]       i_unk_allele_first = '0;
    logic [AL_W-1:0]       i_unk_allele_second = '0;
    logic [AL_W-1:0]       i_rel_allele_first = '0;
    logic [AL_W-1:0]       i_rel_allele_second = '0;
    logic [FREQ_W-1:0]     i_freq_first = '0;
    logic [FREQ_W-1:0]     i_freq_second = '0;
    logic [CNT_W-1:0]      i_count_first = '0;
    logic [CNT_W-1:0]      i_count_second = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [PROB_W-1:0]     o_probability;

    // one genotype query as presented on the input port
    typedef struct {
        logic [GENO_W-1:0] ug, rg;
        logic              rel;
        logic [AL_W-1:0]   ua, ub, ra, rb;
        logic [FREQ_W-1:0] f1, f2;
        logic [CNT_W-1:0]  c1, c2;
    } t_query;

    // local copy of the register file
    logic [THETA_W-1:0] m_theta = '0;
    logic [CNT_W-1:0]   m_total = '0;
    logic [KAPPA_W-1:0] m_k0 = 17'd65536;
    logic [KAPPA_W-1:0] m_k1 = '0;
    logic [KAPPA_W-1:0] m_k2 = '0;

    logic [PROB_W-1:0] prob_fifo[$];
    int unsigned cycles = 0, mismatches = 0, n_sent = 0, n_checked = 0;
    int unsigned n_rel = 0, n_same = 0;

    kinship_genotype_probability u_dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, prob_fifo.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [63:0] rnd_shift(logic [63:0] x, int s);
        return ((x >> (s - 1)) + 64'd1) >> 1;
    endfunction

    // theta-corrected allele probability, Q30, saturated
    function automatic logic [63:0] allele_p(logic [63:0] f, logic [63:0] c, logic [63:0] n);
        logic [63:0] th, num, den, p;
        th  = 64'(m_theta);
        num = ((c * th) << 16) + (64'd65536 - th) * f;
        den = 64'd65536 + n * th - th;
        p   = ((num << 14) + (den >> 1)) / den;
        return (p > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : p;
    endfunction

    function automatic logic [PROB_W-1:0] genotype_prob(t_query q);
        logic [63:0] pa, pb, pc, g, n, k0, k1;
        logic        uhom, ash, bsh;
        n    = 64'(m_total);
        k0   = 64'(m_k0);
        k1   = 64'(m_k1);
        uhom = q.ua == q.ub;   // AL_W bits already reduce modulo 64
        pa   = allele_p(64'(q.f1), 64'(q.c1), n);
        pb   = allele_p(64'(q.f2), 64'(q.c2), n);
        if (uhom)
            g = rnd_shift(pa * allele_p(64'(q.f1), 64'(q.c1) + 64'd1, n + 64'd1), 30);
        else
            g = 64'd2 * rnd_shift(pa * allele_p(64'(q.f2), 64'(q.c2), n + 64'd1), 30);
        if (q.rel) begin
            g = rnd_shift(g * k0, 16);
            ash = q.ua == q.ra || q.ua == q.rb;
            bsh = q.ub == q.ra || q.ub == q.rb;
            if (q.ug == q.rg) begin
                g += 64'(m_k2) << 14;
                g += uhom ? rnd_shift(pa * k1, 16) : rnd_shift((pa + pb) * k1, 17);
            end else if (ash || bsh) begin
                if (uhom) begin
                    g += rnd_shift(pa * k1, 17);
                end else begin
                    pc = ash ? pb : pa;
                    g += rnd_shift(pc * k1, (q.ra == q.rb) ? 16 : 17);
                end
            end
        end
        return (g > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : g[31:0];
    endfunction

    task automatic set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_THETA:       m_theta = val[THETA_W-1:0];
            CFG_TYPED_TOTAL: m_total = val[CNT_W-1:0];
            CFG_KAPPA_ZERO:  m_k0 = val;
            CFG_KAPPA_ONE:   m_k1 = val;
            default:         m_k2 = val;
        endcase
    endtask

    task automatic set_all(logic [15:0] th, logic [9:0] tot, logic [16:0] k0,
                           logic [16:0] k1, logic [16:0] k2);
        set_reg(CFG_THETA, 17'(th));
        set_reg(CFG_TYPED_TOTAL, 17'(tot));
        set_reg(CFG_KAPPA_ZERO, k0);
        set_reg(CFG_KAPPA_ONE, k1);
        set_reg(CFG_KAPPA_TWO, k2);
    endtask

    // sends one transaction after a random gap; valid stays high back to back
    task automatic send_query(t_query q, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5));
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid             <= 1'b1;
        i_unknown_geno      <= q.ug;
        i_related_geno      <= q.rg;
        i_related_present   <= q.rel;
        i_unk_allele_first  <= q.ua;
        i_unk_allele_second <= q.ub;
        i_rel_allele_first  <= q.ra;
        i_rel_allele_second <= q.rb;
        i_freq_first        <= q.f1;
        i_freq_second       <= q.f2;
        i_count_first       <= q.c1;
        i_count_second      <= q.c2;
        prob_fifo.push_back(genotype_prob(q));
        n_sent++;
        if (q.rel) n_rel++;
        if (q.rel && q.ug == q.rg) n_same++;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic idle_until_drained();
        i_valid <= 1'b0;
        while (prob_fifo.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    function automatic t_query rand_query();
        t_query q;
        q.ug  = GENO_W'($urandom_range(0, 4095));
        q.rel = $urandom_range(0, 3) != 0;
        // bias toward same genotype and shared alleles to reach the kappa terms
        case ($urandom_range(0, 3))
            0:       q.rg = q.ug;
            default: q.rg = GENO_W'($urandom_range(0, 4095));
        endcase
        q.ua = AL_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                  : $urandom_range(0, 5));
        q.ub = ($urandom_range(0, 3) == 0) ? q.ua : AL_W'($urandom_range(0, 7));
        q.ra = ($urandom_range(0, 1) != 0) ? q.ua : AL_W'($urandom_range(0, 63));
        q.rb = ($urandom_range(0, 2) == 0) ? q.ra : AL_W'($urandom_range(0, 63));
        if ($urandom_range(0, 1)) {q.ra, q.rb} = {q.rb, q.ra};
        q.f1 = FREQ_W'($urandom_range(0, 65535));
        q.f2 = FREQ_W'($urandom_range(0, 65535));
        q.c1 = CNT_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                   : $urandom_range(0, 20));
        q.c2 = CNT_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                   : $urandom_range(0, 20));
        return q;
    endfunction

    function automatic t_query mk(logic [11:0] ug, rg, logic rel, logic [5:0] ua, ub, ra, rb,
                                  logic [15:0] f1, f2, logic [9:0] c1, c2);
        t_query q;
        q.ug = ug; q.rg = rg; q.rel = rel;
        q.ua = ua; q.ub = ub; q.ra = ra; q.rb = rb;
        q.f1 = f1; q.f2 = f2; q.c1 = c1; q.c2 = c2;
        return q;
    endfunction

    // output side: compare in order
    always @(posedge i_clk) begin
        logic [PROB_W-1:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (prob_fifo.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", o_probability);
            end else begin
                want = prob_fifo.pop_front();
                n_checked++;
                if (o_probability !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("probability mismatch: expected %h got %h", want,
                                 o_probability);
                end
            end
        end
    end

    // stall pattern: stretches of no stall, otherwise random stall bursts
    initial begin
        int s;
        forever begin
            if ($urandom_range(0, 3) == 0) begin
                i_stall <= 1'b0;
                repeat ($urandom_range(20, 60)) @(posedge i_clk);
            end else begin
                s = $urandom_range(0, 5);
                i_stall <= s != 0;
                repeat (s > 0 ? s : 1) @(posedge i_clk);
                i_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    // reset values, then field extremes, homozygote and heterozygote
    task automatic test_reset_defaults();
        send_query(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_query(mk(12'hFFF, 12'hFFF, 1, 63, 63, 63, 63, 16'hFFFF, 16'hFFFF, 1023, 1023));
        send_query(mk(5, 6, 0, 1, 2, 3, 4, 16'h8000, 16'h4000, 0, 0));
        idle_until_drained();
    endtask

    // every relative case: same genotype, shared alleles, halving, none shared
    task automatic test_kinship_cases();
        set_all(16'd655, 10'd20, 17'd32768, 17'd32768, 17'd16384);
        send_query(mk(10, 10, 1, 3, 3, 3, 3, 16'h2000, 16'h2000, 2, 2));
        send_query(mk(10, 10, 1, 3, 4, 3, 4, 16'h2000, 16'h1000, 2, 1));
        send_query(mk(10, 11, 1, 3, 3, 3, 7, 16'h2000, 16'h1000, 2, 1));
        send_query(mk(10, 11, 1, 3, 4, 3, 3, 16'h2000, 16'h1000, 2, 1));
        send_query(mk(10, 11, 1, 3, 4, 3, 9, 16'h2000, 16'h1000, 2, 1));
        send_query(mk(10, 11, 1, 3, 4, 9, 4, 16'h2000, 16'h1000, 2, 1));
        send_query(mk(10, 11, 1, 3, 4, 8, 9, 16'h2000, 16'h1000, 2, 1));
        send_query(mk(10, 11, 0, 3, 4, 3, 4, 16'h2000, 16'h1000, 2, 1));
        send_query(mk(1, 2, 1, 0, 63, 63, 0, 16'hFFFF, 0, 1023, 0));
        idle_until_drained();
    endtask

    // register extremes push the result into saturation
    task automatic test_saturation();
        set_all(16'hFFFF, 10'd0, 17'd65536, 17'd65536, 17'd65536);
        send_query(mk(7, 7, 1, 2, 2, 2, 2, 16'hFFFF, 16'hFFFF, 1023, 1023));
        send_query(mk(7, 7, 1, 2, 5, 2, 5, 16'hFFFF, 16'hFFFF, 1023, 1023));
        idle_until_drained();
        set_all(16'hFFFF, 10'd1023, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        send_query(mk(7, 7, 1, 2, 5, 2, 5, 16'hFFFF, 16'hFFFF, 1023, 1023));
        send_query(mk(7, 8, 1, 2, 2, 9, 9, 0, 0, 0, 0));
        idle_until_drained();
    endtask

    // random phases over several register settings
    task automatic test_random_traffic();
        for (int ph = 0; ph < 6; ph++) begin
            set_all(THETA_W'($urandom_range(0, 6000)), CNT_W'($urandom_range(0, 200)),
                    KAPPA_W'($urandom_range(0, 65536)), KAPPA_W'($urandom_range(0, 65536)),
                    KAPPA_W'($urandom_range(0, 65536)));
            if (ph == 5) set_all(THETA_W'($urandom_range(0, 65535)),
                                 CNT_W'($urandom_range(0, 1023)),
                                 KAPPA_W'($urandom_range(0, 131071)),
                                 KAPPA_W'($urandom_range(0, 131071)),
                                 KAPPA_W'($urandom_range(0, 131071)));
            for (int i = 0; i < N_RANDOM / 6; i++) begin
                send_query(rand_query(), i % 50 < 10);
                // once per phase, hold off until the pipeline has emptied
                if (i == 100) begin
                    i_valid <= 1'b0;
                    while (prob_fifo.size() != 0) @(posedge i_clk);
                end
            end
            idle_until_drained();
        end
    endtask

    initial begin
        int unsigned wait_cyc;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_kinship_cases();
        test_saturation();
        test_random_traffic();
        wait_cyc = 0;
        while (prob_fifo.size() != 0 && wait_cyc < 10000) begin
            @(posedge i_clk);
            wait_cyc++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("covered %0d queries (%0d with a relative, %0d same genotype), %0d checked",
                 n_sent, n_rel, n_same, n_checked);
        $display("register settings from reset values to full-scale saturation");
        if (mismatches == 0 && prob_fifo.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, prob_fifo.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
